// ===== hw/rtl/radio_packet_framer_defines.svh =====
// Assertion helpers shared by the framer RTL.
`ifndef RADIO_PACKET_FRAMER_DEFINES_SVH
`define RADIO_PACKET_FRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RPF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rpf assertion failed");

// Next-cycle implication, checked outside reset.
`define RPF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rpf assertion failed");

`endif

// ===== hw/rtl/rpf_pkg.sv =====
`timescale 1ns / 1ps
package rpf_pkg;

  localparam logic       MODE_START = 1'b0;
  localparam logic       MODE_DATA  = 1'b1;

  localparam logic [7:0]  FILL_BYTE  = 8'hAA;
  localparam logic [15:0] SYNC_RESET = 16'h2DD4;

  localparam int QUEUE_DEPTH = 2;

  // Byte positions within the back-end sequence.
  localparam int          POS_W       = 4;
  localparam logic [3:0]  POS_FIRST   = 4'd0;
  localparam logic [3:0]  POS_SYNC_HI = 4'd3;
  localparam logic [3:0]  POS_SYNC_LO = 4'd4;
  localparam logic [3:0]  POS_VALUE   = 4'd5;
  localparam logic [3:0]  POS_CSUM    = 4'd6;
  localparam logic [3:0]  POS_LAST    = 4'd9;

  typedef struct packed {
    logic       mode;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_item_t;

  // Work handed from front to back.
  typedef struct packed {
    logic       is_start;  // emit header before value
    logic [7:0] value;     // length byte or payload byte
    logic       trailer;   // append checksum and postamble
    logic [7:0] csum;
  } cmd_t;

endpackage

// ===== hw/rtl/rpf_front.sv =====
`timescale 1ns / 1ps
`include "radio_packet_framer_defines.svh"
module rpf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  rpf_pkg::in_item_t in_item,
  output logic             push,
  output rpf_pkg::cmd_t    push_cmd,
  input  logic             q_ready
);

  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic       frame_open, frame_open_next;
  logic       take;
  logic [7:0] sum_add;
  logic [7:0] left_dec;

  assign in_ready = q_ready;
  assign take     = in_valid && in_ready;
  assign sum_add  = running_sum + in_item.payload_byte;
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    frame_open_next  = frame_open;
    push             = 1'b0;
    push_cmd         = '0;
    if (take) begin
      if (in_item.mode == rpf_pkg::MODE_START) begin
        push              = 1'b1;
        push_cmd.is_start = 1'b1;
        push_cmd.value    = in_item.payload_length;
        push_cmd.trailer  = (in_item.payload_length == 8'd0);
        push_cmd.csum     = 8'd0;
        running_sum_next  = 8'd0;
        bytes_left_next   = in_item.payload_length;
        frame_open_next   = (in_item.payload_length != 8'd0);
      end else if (frame_open) begin
        push              = 1'b1;
        push_cmd.is_start = 1'b0;
        push_cmd.value    = in_item.payload_byte;
        push_cmd.trailer  = (left_dec == 8'd0);
        push_cmd.csum     = sum_add;
        running_sum_next  = sum_add;
        bytes_left_next   = left_dec;
        frame_open_next   = (left_dec != 8'd0);
      end
      // data outside a frame is dropped
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= '0;
      running_sum <= '0;
      frame_open  <= 1'b0;
    end else begin
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      frame_open  <= frame_open_next;
    end
  end

  `RPF_ASSERT_IMP(a_open_has_bytes, clk, rst, frame_open, bytes_left != 8'd0)
  `RPF_ASSERT_IMP(a_trailer_closes, clk, rst, push && push_cmd.trailer, !frame_open_next)
  `RPF_ASSERT_NXT(a_start_clears_sum, clk, rst,
                  take && in_item.mode == rpf_pkg::MODE_START, running_sum == 8'd0)

endmodule

// ===== hw/rtl/rpf_queue.sv =====
`timescale 1ns / 1ps
`include "radio_packet_framer_defines.svh"
module rpf_queue #(
  parameter int DEPTH = rpf_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rpf_pkg::cmd_t push_cmd,
  output logic          q_ready,
  input  logic          pop,
  output logic          head_valid,
  output rpf_pkg::cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  rpf_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_ready    = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RPF_ASSERT_IMP(a_no_overflow, clk, rst, push, q_ready || pop)
  `RPF_ASSERT_IMP(a_no_underflow, clk, rst, pop, head_valid)

endmodule

// ===== hw/rtl/rpf_back.sv =====
`timescale 1ns / 1ps
`include "radio_packet_framer_defines.svh"
module rpf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic [15:0]        sync_word,
  input  logic               head_valid,
  input  rpf_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rpf_pkg::out_item_t out_item
);

  logic                      busy;
  rpf_pkg::cmd_t             cur;
  logic [rpf_pkg::POS_W-1:0] pos;

  rpf_pkg::cmd_t             act_cmd;
  logic [rpf_pkg::POS_W-1:0] act_pos;
  logic [rpf_pkg::POS_W-1:0] end_pos;
  logic                      active;
  logic                      load;
  logic                      done;
  logic [7:0]                byte_sel;

  assign act_cmd = busy ? cur : head;
  assign act_pos = busy ? pos :
                   (head.is_start ? rpf_pkg::POS_FIRST : rpf_pkg::POS_VALUE);
  assign end_pos = act_cmd.trailer ? rpf_pkg::POS_LAST : rpf_pkg::POS_VALUE;
  assign active  = busy || head_valid;
  // output register refills when empty or being drained
  assign load    = active && (!out_valid || out_ready);
  assign done    = (act_pos == end_pos);
  assign pop     = load && !busy;

  always_comb begin
    unique case (act_pos)
      rpf_pkg::POS_SYNC_HI: byte_sel = sync_word[15:8];
      rpf_pkg::POS_SYNC_LO: byte_sel = sync_word[7:0];
      rpf_pkg::POS_VALUE:   byte_sel = act_cmd.value;
      rpf_pkg::POS_CSUM:    byte_sel = act_cmd.csum;
      default:              byte_sel = rpf_pkg::FILL_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        busy      <= !done;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur                <= act_cmd;
      pos                <= act_pos + 1'b1;
      out_item.out_byte  <= byte_sel;
      out_item.frame_end <= (act_pos == rpf_pkg::POS_LAST);
    end
  end

  `RPF_ASSERT_IMP(a_end_is_fill, clk, rst, out_valid && out_item.frame_end,
                  out_item.out_byte == rpf_pkg::FILL_BYTE)
  `RPF_ASSERT_IMP(a_busy_in_range, clk, rst, busy,
                  pos != rpf_pkg::POS_FIRST && (pos <= rpf_pkg::POS_VALUE || cur.trailer))
  `RPF_ASSERT_NXT(a_last_byte_frees, clk, rst, load && done, !busy)

endmodule

// ===== hw/rtl/radio_packet_framer.sv =====
`timescale 1ns / 1ps
// Radio packet framer. A start item (mode 0) produces six bytes: three 0xAA
// preamble bytes, the sync word high byte first, and the length; with a zero
// length it goes on with the checksum 0x00 and three 0xAA postamble bytes, ten
// bytes in all. A data item (mode 1) inside a frame produces its byte, plus the
// checksum and postamble when it is the last payload byte; data outside a frame
// is dropped. frame_end marks the final postamble byte. The output sequencer
// emits one byte per cycle and mid-frame data flows at one item per cycle while
// out_ready is high; an item holds the output until its last byte (of 1, 5, 6
// or 10) is sent. A command queue of QUEUE_DEPTH entries lets the input keep
// accepting items while a header or trailer is being sent. sync_word may be
// written only while the framer is idle; cfg_ready is always high.
module radio_packet_framer #(
  parameter int QUEUE_DEPTH = rpf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpf_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output rpf_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic          push;
  rpf_pkg::cmd_t push_cmd;
  logic          q_ready;
  logic          pop;
  logic          head_valid;
  rpf_pkg::cmd_t head;
  logic [15:0]   sync_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= rpf_pkg::SYNC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sync_word <= cfg_data;
    end
  end

  rpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready)
  );

  rpf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .sync_word  (sync_word),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== tb/tb_radio_packet_framer.sv =====
`timescale 1ns / 1ps
module tb_radio_packet_framer;

  localparam int STALL_LIMIT = 3000;  // cycles with no handshake on any channel
  localparam int CFG_SETTLE  = 20;    // covers items that drain without output
  localparam int TAIL_CYCLES = 30;
  localparam int RAND_ITEMS  = 300;

  localparam logic       M_START = rpf_pkg::MODE_START;
  localparam logic       M_DATA  = rpf_pkg::MODE_DATA;
  localparam logic [7:0] FILL    = rpf_pkg::FILL_BYTE;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // bytes holds the typed-in frame bytes right aligned, first byte highest
  typedef struct packed {
    row_kind_t         kind;
    logic [15:0]       sync;
    rpf_pkg::in_item_t item;
    logic              typed;
    logic [3:0]        n;
    logic              ends;
    logic [79:0]       bytes;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{ROW_ITEM, 16'h0, '{M_START, 8'h00, 8'h00}, 1'b1, 4'd10, 1'b1,
      80'hAAAAAA2DD40000AAAAAA},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'hFF, 8'h5A}, 1'b1, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h01, 8'hFF}, 1'b1, 4'd6, 1'b0, 80'hAAAAAA2DD401},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'hFF, 8'hFF}, 1'b1, 4'd5, 1'b1, 80'hFFFFAAAAAA},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h03, 8'h00}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h80}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h80}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h01}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h02, 8'h00}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h11}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h02, 8'h00}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h22}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h33}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'hFF, 8'h00}, 1'b1, 4'd6, 1'b0, 80'hAAAAAA2DD4FF},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h00}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h00, 8'hFF}, 1'b1, 4'd10, 1'b1,
      80'hAAAAAA2DD40000AAAAAA},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h00}, 1'b1, 4'd0, 1'b0, 80'h0},
    '{ROW_CFG, 16'h0000, '{M_START, 8'h00, 8'h00}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h00, 8'h00}, 1'b1, 4'd10, 1'b1,
      80'hAAAAAA00000000AAAAAA},
    '{ROW_CFG, 16'hFFFF, '{M_START, 8'h00, 8'h00}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h01, 8'h00}, 1'b1, 4'd6, 1'b0, 80'hAAAAAAFFFF01},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h00}, 1'b1, 4'd5, 1'b1, 80'h0000AAAAAA},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h80, 8'h00}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_DATA, 8'h00, 8'h7F}, 1'b0, 4'd0, 1'b0, 80'h0},
    '{ROW_ITEM, 16'h0, '{M_START, 8'h00, 8'h00}, 1'b1, 4'd10, 1'b1,
      80'hAAAAAAFFFF0000AAAAAA}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  rpf_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_ready;
  rpf_pkg::out_item_t out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [15:0]        cfg_data;

  radio_packet_framer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // framer state as the frame builder sees it
  logic [15:0] tx_sync;
  logic [7:0]  pend_len;
  logic [7:0]  pay_sum;
  logic        in_frame;

  rpf_pkg::out_item_t frame_bytes [10];
  int                 frame_n;
  rpf_pkg::out_item_t pending_bytes [$];

  int  fail_cnt;
  int  items_done;
  int  idle_cycles;
  bit  src_calm;
  bit  sink_calm;

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last);
    frame_bytes[frame_n] = '{out_byte: b, frame_end: last};
    frame_n++;
  endtask

  task automatic close_frame();
    add_byte(pay_sum, 1'b0);
    add_byte(FILL, 1'b0);
    add_byte(FILL, 1'b0);
    add_byte(FILL, 1'b1);
    in_frame = 1'b0;
    pend_len = 8'd0;
  endtask

  task automatic build_frame_bytes(input rpf_pkg::in_item_t it);
    frame_n = 0;
    if (it.mode == M_START) begin
      add_byte(FILL, 1'b0);
      add_byte(FILL, 1'b0);
      add_byte(FILL, 1'b0);
      add_byte(tx_sync[15:8], 1'b0);
      add_byte(tx_sync[7:0], 1'b0);
      add_byte(it.payload_length, 1'b0);
      pay_sum = 8'd0;
      pend_len = it.payload_length;
      in_frame = 1'b1;
      if (it.payload_length == 8'd0) close_frame();
    end else if (in_frame) begin
      add_byte(it.payload_byte, 1'b0);
      pay_sum = pay_sum + it.payload_byte;
      pend_len = pend_len - 8'd1;
      if (pend_len == 8'd0) close_frame();
    end
  endtask

  // entered and left at a falling edge; valid stays high on return
  task automatic send_item(input rpf_pkg::in_item_t it, input logic typed,
                           input logic [3:0] n, input logic ends,
                           input logic [79:0] bytes);
    int gap;
    rpf_pkg::out_item_t o;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    build_frame_bytes(it);
    if (typed) begin
      for (int i = 0; i < n; i++) begin
        o.out_byte  = bytes[8 * (n - 1 - i) +: 8];
        o.frame_end = ends && (i == n - 1);
        pending_bytes.push_back(o);
      end
    end else begin
      for (int i = 0; i < frame_n; i++) pending_bytes.push_back(frame_bytes[i]);
    end
    if (frame_n > 0) items_done++;
    @(negedge clk);
  endtask

  task automatic write_sync(input logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    tx_sync = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // output side: random backpressure
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = pick_gap(sink_calm);
      end
    end
  end

  always @(posedge clk) begin
    rpf_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected byte %02h end %0b with nothing pending",
                   out_item.out_byte, out_item.frame_end);
      end else begin
        want = pending_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte || out_item.frame_end !== want.frame_end) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                     want.out_byte, want.frame_end, out_item.out_byte, out_item.frame_end);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rpf_pkg::in_item_t it;
    logic [7:0]        len;
    int                r;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    fail_cnt   = 0;
    items_done = 0;
    idle_cycles = 0;
    src_calm   = 1'b0;
    sink_calm  = 1'b0;
    tx_sync    = rpf_pkg::SYNC_RESET;
    pend_len   = 8'd0;
    pay_sum    = 8'd0;
    in_frame   = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < DIR_ROWS; k++) begin
      if (DIR_TAB[k].kind == ROW_CFG)
        write_sync(DIR_TAB[k].sync);
      else
        send_item(DIR_TAB[k].item, DIR_TAB[k].typed, DIR_TAB[k].n,
                  DIR_TAB[k].ends, DIR_TAB[k].bytes);
    end

    // mostly whole frames with random content; some restarts and stray data
    items_done = 0;
    while (items_done < RAND_ITEMS) begin
      src_calm  = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) write_sync(16'($urandom_range(0, 65535)));
      r = $urandom_range(0, 99);
      if (r < 65) len = 8'($urandom_range(0, 6));
      else if (r < 95) len = 8'($urandom_range(7, 40));
      else len = 8'($urandom_range(41, 255));
      it.mode           = M_START;
      it.payload_length = len;
      it.payload_byte   = 8'($urandom_range(0, 255));
      send_item(it, 1'b0, 4'd0, 1'b0, 80'h0);
      for (int b = 0; b < len && items_done < RAND_ITEMS; b++) begin
        if ($urandom_range(0, 49) == 0) break;  // abandon; next start restarts
        it.mode           = M_DATA;
        it.payload_length = 8'($urandom_range(0, 255));
        it.payload_byte   = 8'($urandom_range(0, 255));
        send_item(it, 1'b0, 4'd0, 1'b0, 80'h0);
      end
      if ($urandom_range(0, 7) == 0) begin
        it.mode           = M_DATA;
        it.payload_length = 8'($urandom_range(0, 255));
        it.payload_byte   = 8'($urandom_range(0, 255));
        send_item(it, 1'b0, 4'd0, 1'b0, 80'h0);
      end
    end

    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rpf_pkg.sv
hw/rtl/rpf_front.sv
hw/rtl/rpf_queue.sv
hw/rtl/rpf_back.sv
hw/rtl/radio_packet_framer.sv
tb/tb_radio_packet_framer.sv
